// ===== hdl/normal_vector_texel_normalizer_defines.svh =====
// Assertion macros for the texel normalizer checker.
`ifndef NORMAL_VECTOR_TEXEL_NORMALIZER_DEFINES_SVH
`define NORMAL_VECTOR_TEXEL_NORMALIZER_DEFINES_SVH

// same-cycle implication, off during reset
`define NVTN_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, off during reset
`define NVTN_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// next-cycle implication, checked during reset as well
`define NVTN_ASSERT_RST(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("reset check failed");

`endif

// ===== hdl/nvtn_pkg.sv =====
// Types, constants, bit-test step and encoder for the texel normalizer pipeline.
package nvtn_pkg;

  localparam int K_W        = 7;
  localparam int S_W        = 18;
  localparam int RHS_W      = 32;
  localparam int SQ_W       = 16;
  localparam int KSQ_W      = 2 * K_W;
  localparam int PROD_W     = RHS_W + 2;
  localparam int BIT_STAGES = K_W;
  localparam int LANES      = 3;

  localparam logic [SQ_W-1:0] SCALE_SQ = 16'd65025;
  localparam logic [7:0]      MID_CODE = 8'd128;

  typedef struct packed {
    logic [K_W-1:0]   k;
    logic [KSQ_W-1:0] ksq;
    logic             eq;
    logic             neg;
  } lane_t;

  typedef struct packed {
    logic [LANES-1:0][SQ_W-1:0] sq;
    logic [LANES-1:0]           neg;
    logic [7:0]                 alpha;
  } dec_t;

  typedef struct packed {
    logic [S_W-1:0]              s;
    logic [LANES-1:0][RHS_W-1:0] rhs;
    lane_t [LANES-1:0]           lane;
    logic [7:0]                  alpha;
  } stage_t;

  function automatic lane_t bit_step(lane_t l, logic [S_W-1:0] s,
                                     logic [RHS_W-1:0] rhs, int b);
    logic [K_W-1:0]    c;
    logic [KSQ_W-1:0]  csq;
    logic [RHS_W-1:0]  m;
    logic [PROD_W-1:0] prod;
    lane_t             r;
    c    = l.k | K_W'(1 << b);
    csq  = l.ksq + KSQ_W'({{K_W{1'b0}}, l.k} << (b + 1)) + KSQ_W'(1 << (2 * b));
    m    = RHS_W'(csq) * RHS_W'(s);
    prod = {m, 2'b00};
    r    = l;
    if (prod <= {2'b00, rhs}) begin
      r.k   = c;
      r.ksq = csq;
      r.eq  = (prod == {2'b00, rhs});
    end
    return r;
  endfunction

  function automatic stage_t stage_step(stage_t st, int b);
    stage_t r;
    r = st;
    for (int i = 0; i < LANES; i++) begin
      r.lane[i] = bit_step(st.lane[i], st.s, st.rhs[i], b);
    end
    return r;
  endfunction

  function automatic logic [7:0] encode(lane_t l);
    logic [7:0] e;
    if (l.neg) begin
      e = MID_CODE - {1'b0, l.k} - {7'd0, ~l.eq};
    end else begin
      e = MID_CODE + {1'b0, l.k};
    end
    return e;
  endfunction

endpackage

// ===== hdl/normal_vector_texel_normalizer.sv =====
// Normal-map texel renormalizer: decode, square-sum, bit-serial scale search, encode.
// Pipeline: ten register stages; decode, scale setup, seven bit-test stages, output register.
// Throughput: one texel per cycle unless stalled; seven bit-test stages, one multiplier per lane each.
// Stalls hold only full stages; bubbles close up, so input keeps flowing behind a held result.
// Reset: synchronous, active low; clears all stage valid bits, payload is not reset.
module normal_vector_texel_normalizer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_texel_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_texel_out
);
  import nvtn_pkg::*;

  localparam int NST = BIT_STAGES + 3;

  logic [NST-1:0] vld_r;
  logic [NST-1:0] vld_nxt;
  logic [NST-1:0] rdy;

  dec_t   dec_nxt;
  dec_t   dec_r;
  stage_t init_nxt;
  stage_t st_r [BIT_STAGES+1];
  logic [31:0] out_nxt;

  always_comb begin
    rdy[NST-1] = !vld_r[NST-1] || !out_stall;
    for (int i = NST - 2; i >= 0; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end
  end

  always_comb begin
    vld_nxt[0] = rdy[0] ? in_valid : vld_r[0];
    for (int i = 1; i < NST; i++) begin
      vld_nxt[i] = rdy[i] ? vld_r[i-1] : vld_r[i];
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = vld_r[NST-1];

  always_comb begin
    logic [7:0] b;
    logic [7:0] mag;
    b   = '0;
    mag = '0;
    dec_nxt.alpha = in_texel_in[31:24];
    for (int i = 0; i < LANES; i++) begin
      b  = in_texel_in[8*i +: 8];
      mag = {b[7] ? b[6:0] : ~b[6:0], 1'b1};
      dec_nxt.sq[i]  = SQ_W'(mag) * SQ_W'(mag);
      dec_nxt.neg[i] = ~b[7];
    end
  end

  always_comb begin
    init_nxt.s = S_W'(dec_r.sq[0]) + S_W'(dec_r.sq[1]) + S_W'(dec_r.sq[2]);
    init_nxt.alpha = dec_r.alpha;
    for (int i = 0; i < LANES; i++) begin
      init_nxt.rhs[i]      = RHS_W'(SCALE_SQ) * RHS_W'(dec_r.sq[i]);
      init_nxt.lane[i].k   = '0;
      init_nxt.lane[i].ksq = '0;
      init_nxt.lane[i].eq  = 1'b0;
      init_nxt.lane[i].neg = dec_r.neg[i];
    end
  end

  assign out_nxt = {st_r[BIT_STAGES].alpha,
                    encode(st_r[BIT_STAGES].lane[1]),
                    encode(st_r[BIT_STAGES].lane[2]),
                    encode(st_r[BIT_STAGES].lane[0])};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      dec_r <= dec_nxt;
    end
    if (rdy[1]) begin
      st_r[0] <= init_nxt;
    end
    if (rdy[NST-1]) begin
      out_texel_out <= out_nxt;
    end
  end

  for (genvar j = 0; j < BIT_STAGES; j++) begin : g_bit
    always_ff @(posedge clk) begin
      if (rdy[j+2]) begin
        st_r[j+1] <= stage_step(st_r[j], BIT_STAGES - 1 - j);
      end
    end
  end

endmodule

// ===== hdl/nvtn_checker.sv =====
// Port-level checks for the texel normalizer, bound to the top level.
`include "normal_vector_texel_normalizer_defines.svh"

module nvtn_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_texel_out
);

  `NVTN_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_texel_out))

  `NVTN_ASSERT_IMP(a_stall_only_when_held, clk, rst_n, in_stall, out_valid && out_stall)

  `NVTN_ASSERT_RST(a_reset_empty, clk, !rst_n, !out_valid && !in_stall)

  `NVTN_ASSERT_NXT(a_idle_drains, clk, rst_n, !in_valid && !out_stall, !in_stall)

endmodule

bind normal_vector_texel_normalizer nvtn_checker u_nvtn_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_texel_out (out_texel_out)
);
